>>> src/tdr_pkg.sv
// ----------------------------------------------------------------------------
// tdr_pkg
// Shared widths, register indexes, reset values and item types for the
// throttle duty ramp block.
// ----------------------------------------------------------------------------
package tdr_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int CODE_W      = SAMPLE_BITS;
  localparam int GAIN_W      = 24;
  localparam int OFFSET_W    = 16;
  localparam int RAMP_W      = 24;
  localparam int DUTY_W      = 16;
  localparam int FRAC_W      = 8;
  localparam int PROD_W      = CODE_W + GAIN_W;
  localparam int SCALED_W    = PROD_W - FRAC_W;

  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 24;

  localparam int Q_DEPTH     = 2;
  localparam int Q_PTR_W     = $clog2(Q_DEPTH);
  localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

  localparam logic [RAMP_W-1:0] RAMP_MAX = {RAMP_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OFF_THRESHOLD = 3'd0,
    REG_ON_THRESHOLD  = 3'd1,
    REG_DUTY_GAIN     = 3'd2,
    REG_DUTY_OFFSET   = 3'd3,
    REG_RAMP_STEP     = 3'd4,
    REG_DUTY_LIMIT    = 3'd5
  } tdr_reg_t;

  localparam logic [CODE_W-1:0]   RST_OFF_THRESHOLD = CODE_W'(993);
  localparam logic [CODE_W-1:0]   RST_ON_THRESHOLD  = CODE_W'(1241);
  localparam logic [GAIN_W-1:0]   RST_DUTY_GAIN     = GAIN_W'(179573);
  localparam logic [OFFSET_W-1:0] RST_DUTY_OFFSET   = OFFSET_W'(2540);
  localparam logic [RAMP_W-1:0]   RST_RAMP_STEP     = RAMP_W'(256);
  localparam logic [DUTY_W-1:0]   RST_DUTY_LIMIT    = DUTY_W'(65535);

  typedef struct packed {
    logic [CODE_W-1:0]   off_threshold;
    logic [CODE_W-1:0]   on_threshold;
    logic [GAIN_W-1:0]   duty_gain;
    logic [OFFSET_W-1:0] duty_offset;
  } tdr_front_cfg_t;

  typedef struct packed {
    logic [RAMP_W-1:0] ramp_step;
    logic [DUTY_W-1:0] duty_limit;
  } tdr_back_cfg_t;

  typedef struct packed {
    logic              flag;
    logic [CODE_W-1:0] code;
    logic [RAMP_W-1:0] target;
  } tdr_item_t;

endpackage

>>> src/tdr_if.sv
// ----------------------------------------------------------------------------
// tdr channel interfaces
// Valid/ready channels for samples, duty results and register writes.
// ----------------------------------------------------------------------------
interface tdr_in_if import tdr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] adc_sample;

  modport source (output valid, output adc_sample, input ready);
  modport sink   (input valid, input adc_sample, output ready);
endinterface

interface tdr_out_if import tdr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              throttle_valid;
  logic [CODE_W-1:0] sample_code;
  logic [DUTY_W-1:0] duty_command;

  modport source (output valid, output throttle_valid, output sample_code,
                  output duty_command, input ready);
  modport sink   (input valid, input throttle_valid, input sample_code,
                  input duty_command, output ready);
endinterface

interface tdr_cfg_if import tdr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> src/tdr_front.sv
// ----------------------------------------------------------------------------
// tdr_front
// Accepts samples, runs the hysteresis flag and forms the Q8 target duty.
// ----------------------------------------------------------------------------
module tdr_front import tdr_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  tdr_in_if.sink         in_ch,
  input  tdr_front_cfg_t cfg,
  input  logic           q_full,
  output logic           push,
  output tdr_item_t      push_item
);

  logic              flag;
  logic              flag_next;
  logic              st_valid;
  logic              st_flag;
  logic [CODE_W-1:0] st_code;
  logic [PROD_W-1:0] st_prod;
  logic              accept;

  logic [SCALED_W-1:0] scaled;
  logic [SCALED_W-1:0] off_q8;
  logic [SCALED_W-1:0] diff;
  logic [RAMP_W-1:0]   target;

  assign push         = st_valid && !q_full;
  assign in_ch.ready  = !st_valid || push;
  assign accept       = in_ch.valid && in_ch.ready;

  // clear has priority over set when thresholds cross
  always_comb begin
    if (in_ch.adc_sample < cfg.off_threshold) begin
      flag_next = 1'b0;
    end else if (in_ch.adc_sample > cfg.on_threshold) begin
      flag_next = 1'b1;
    end else begin
      flag_next = flag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flag     <= 1'b0;
      st_valid <= 1'b0;
    end else if (accept) begin
      flag     <= flag_next;
      st_valid <= 1'b1;
    end else if (push) begin
      st_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      st_flag <= flag_next;
      st_code <= in_ch.adc_sample;
      st_prod <= PROD_W'(in_ch.adc_sample) * PROD_W'(cfg.duty_gain);
    end
  end

  assign scaled = st_prod[PROD_W-1:FRAC_W];
  assign off_q8 = SCALED_W'({cfg.duty_offset, {FRAC_W{1'b0}}});
  assign diff   = (scaled > off_q8) ? (scaled - off_q8) : '0;

  always_comb begin
    if (!st_flag) begin
      target = '0;
    end else if (diff > SCALED_W'(RAMP_MAX)) begin
      target = RAMP_MAX;
    end else begin
      target = diff[RAMP_W-1:0];
    end
  end

  assign push_item.flag   = st_flag;
  assign push_item.code   = st_code;
  assign push_item.target = target;

endmodule

>>> src/tdr_queue.sv
// ----------------------------------------------------------------------------
// tdr_queue
// Two-entry queue that decouples the front stage from the ramp stage.
// ----------------------------------------------------------------------------
module tdr_queue import tdr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  tdr_item_t push_item,
  output logic      full,
  input  logic      pop,
  output tdr_item_t pop_item,
  output logic      nonempty
);

  tdr_item_t          mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;

  assign full     = (count == Q_CNT_W'(Q_DEPTH));
  assign nonempty = (count != '0);
  assign pop_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= Q_CNT_W'(Q_DEPTH))
    else $error("queue count above depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (!full || pop))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> nonempty)
    else $error("pop from empty queue");

endmodule

>>> src/tdr_back.sv
// ----------------------------------------------------------------------------
// tdr_back
// Slews the ramp toward the queued target and registers the duty result.
// ----------------------------------------------------------------------------
module tdr_back import tdr_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  tdr_back_cfg_t cfg,
  input  logic          nonempty,
  input  tdr_item_t     item,
  output logic          pop,
  tdr_out_if.source     out_ch
);

  logic [RAMP_W-1:0] ramp;
  logic [RAMP_W-1:0] ramp_next;
  logic [RAMP_W-1:0] base;
  logic [RAMP_W:0]   up_sum;
  logic [RAMP_W-1:0] down_diff;
  logic [DUTY_W-1:0] duty_raw;
  logic [DUTY_W-1:0] duty;
  logic              out_valid;

  assign pop  = nonempty && (!out_valid || out_ch.ready);

  // an invalid throttle drops the ramp to zero
  assign base      = item.flag ? ramp : '0;
  assign up_sum    = {1'b0, base} + {1'b0, cfg.ramp_step};
  assign down_diff = base - item.target;

  always_comb begin
    if (base < item.target) begin
      ramp_next = (up_sum > {1'b0, item.target}) ? item.target : up_sum[RAMP_W-1:0];
    end else if (base > item.target) begin
      ramp_next = (down_diff > cfg.ramp_step) ? (base - cfg.ramp_step) : item.target;
    end else begin
      ramp_next = base;
    end
  end

  assign duty_raw = ramp_next[RAMP_W-1:FRAC_W];
  assign duty     = (duty_raw > cfg.duty_limit) ? cfg.duty_limit : duty_raw;

  always_ff @(posedge clk) begin
    if (rst) begin
      ramp      <= '0;
      out_valid <= 1'b0;
    end else if (pop) begin
      ramp      <= ramp_next;
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_ch.throttle_valid <= item.flag;
      out_ch.sample_code    <= item.code;
      out_ch.duty_command   <= duty;
    end
  end

  assign out_ch.valid = out_valid;

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ch.throttle_valid) |-> (out_ch.duty_command == '0))
    else $error("duty nonzero while throttle invalid");

  a_duty_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_ch.duty_command <= cfg.duty_limit))
    else $error("duty above limit");

  a_ramp_step: assert property (@(posedge clk) disable iff (rst)
    (pop && item.flag) |=> ((ramp >= $past(ramp) && ramp - $past(ramp) <= $past(cfg.ramp_step))
      || (ramp < $past(ramp) && $past(ramp) - ramp <= $past(cfg.ramp_step))))
    else $error("ramp moved more than one step");

endmodule

>>> src/throttle_duty_ramp_unit.sv
// ----------------------------------------------------------------------------
// throttle_duty_ramp_unit
// Throttle sample to slew-limited PWM duty with hysteresis enable.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                     transfer when
//  in_ch    in   adc_sample                                  valid & ready
//  out_ch   out  throttle_valid, sample_code, duty_command   valid & ready
//  cfg      in   index, data                                 valid (ready held high)
//
//  one sample per clock sustained while out_ch.ready is held high; an input transfer
//  reaches the result through the product register, two-entry queue and result register
//  the flag register in the front end and the ramp register in the back end
//  are the only datapath loops
//  synchronous reset restores register defaults and clears flag and ramp
//  a stalled output fills the queue, then the front register, then drops in_ch.ready
// ----------------------------------------------------------------------------
module throttle_duty_ramp_unit import tdr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  tdr_in_if.sink     in_ch,
  tdr_out_if.source  out_ch,
  tdr_cfg_if.sink    cfg
);

  tdr_front_cfg_t front_cfg;
  tdr_back_cfg_t  back_cfg;
  logic           push;
  logic           pop;
  logic           q_full;
  logic           q_nonempty;
  tdr_item_t      push_item;
  tdr_item_t      pop_item;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      front_cfg.off_threshold <= RST_OFF_THRESHOLD;
      front_cfg.on_threshold  <= RST_ON_THRESHOLD;
      front_cfg.duty_gain     <= RST_DUTY_GAIN;
      front_cfg.duty_offset   <= RST_DUTY_OFFSET;
      back_cfg.ramp_step      <= RST_RAMP_STEP;
      back_cfg.duty_limit     <= RST_DUTY_LIMIT;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_OFF_THRESHOLD: front_cfg.off_threshold <= cfg.data[CODE_W-1:0];
        REG_ON_THRESHOLD:  front_cfg.on_threshold  <= cfg.data[CODE_W-1:0];
        REG_DUTY_GAIN:     front_cfg.duty_gain     <= cfg.data[GAIN_W-1:0];
        REG_DUTY_OFFSET:   front_cfg.duty_offset   <= cfg.data[OFFSET_W-1:0];
        REG_RAMP_STEP:     back_cfg.ramp_step      <= cfg.data[RAMP_W-1:0];
        REG_DUTY_LIMIT:    back_cfg.duty_limit     <= cfg.data[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  tdr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .cfg       (front_cfg),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  tdr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .pop_item  (pop_item),
    .nonempty  (q_nonempty)
  );

  tdr_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (back_cfg),
    .nonempty (q_nonempty),
    .item     (pop_item),
    .pop      (pop),
    .out_ch   (out_ch)
  );

endmodule
